/* rtl/spd_pkg.sv */
// Shared types, constants and a helper function of the sensor packet deframer.
package spd_pkg;

   localparam int MAX_PAYLOAD_DEFAULT = 64;
   localparam int MAX_WORDS           = 8;
   localparam int QUEUE_DEPTH         = 4;
   // Wide enough for any byte position at the largest supported payload.
   localparam int POS_W               = 10;

   localparam logic [7:0]  START_BYTE       = 8'h3A;
   localparam logic [7:0]  TRAIL_CR         = 8'h0D;
   localparam logic [7:0]  TRAIL_LF         = 8'h0A;
   localparam logic [15:0] SENSOR_ID_RESET  = 16'd1;
   localparam logic [31:0] TIMEOUT_RESET    = 32'd100000;

   localparam logic CSR_SENSOR_ID    = 1'b0;
   localparam logic CSR_READ_TIMEOUT = 1'b1;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_BAD_START = 3'd1,
      ST_WRONG_ID  = 3'd2,
      ST_BAD_CMD   = 3'd3,
      ST_TRAILER   = 3'd4,
      ST_CHECKSUM  = 3'd5,
      ST_TIMEOUT   = 3'd6,
      ST_TOO_LONG  = 3'd7
   } status_type;

   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_DATA  = 2'd1,
      OP_ERROR = 2'd2
   } op_kind_type;

   typedef struct packed {
      logic       operation;
      logic [7:0] byte_0;
      logic [7:0] byte_1;
      logic [7:0] byte_2;
      logic [7:0] byte_3;
      logic [7:0] byte_4;
      logic [7:0] byte_5;
      logic [7:0] byte_6;
      logic [7:0] byte_7;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] command;
      logic [15:0] payload_length;
      logic [2:0]  word_index;
      logic [63:0] payload_word;
      logic        last;
   } rsp_type;

   // One classified request handed from the front to the back.
   typedef struct packed {
      op_kind_type     kind;
      logic            final_frame;
      logic [2:0]      status;
      logic [15:0]     command;
      logic [15:0]     length;
      logic [POS_W-1:0] pos;
      logic [3:0]      count;
      logic [7:0][7:0] bytes;
   } op_type;

   function automatic logic command_known(input logic [15:0] cmd);
      logic ok;
      unique case (cmd)
         16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd6, 16'd7,
         16'd9, 16'd10, 16'd11, 16'd20, 16'd21, 16'd25, 16'd26, 16'd31,
         16'd32, 16'd33, 16'd34, 16'd41, 16'd42, 16'd43, 16'd44, 16'd60,
         16'd61, 16'd66, 16'd67, 16'd68, 16'd75, 16'd84, 16'd85, 16'd86: ok = 1'b1;
         default: ok = 1'b0;
      endcase
      return ok;
   endfunction

endpackage

/* rtl/spd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module spd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/spd_queue.sv */
// Short request queue between the classifying front and the executing back.
module spd_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  spd_pkg::op_type push_op,
   output logic            full,
   input  logic            pop,
   output spd_pkg::op_type head_op,
   output logic            empty
);

   localparam int DEPTH = spd_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);

   spd_pkg::op_type  entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == (PTR_W+1)'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head_op = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

/* rtl/spd_front.sv */
// Front end: accepts frames and ticks, checks headers, tracks frames and timeout.
module spd_front #(
   parameter int MAX_PAYLOAD = spd_pkg::MAX_PAYLOAD_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  spd_pkg::req_type req,
   input  logic [15:0]      sensor_id,
   input  logic [31:0]      read_timeout,
   output logic             op_valid,
   output spd_pkg::op_type  op
);

   localparam int MAX_FRAMES = (MAX_PAYLOAD + 18) / 8 - 1;
   localparam int FRAME_W    = $clog2(MAX_FRAMES + 1);

   logic               collecting_ff, collecting_in;
   logic [FRAME_W-1:0] seen_ff, seen_in;
   logic [FRAME_W-1:0] left_ff, left_in;
   logic [31:0]        elapsed_ff, elapsed_in;
   logic [15:0]        cmd_ff, cmd_in;
   logic [15:0]        len_ff, len_in;

   logic [15:0]        hdr_id, hdr_cmd, hdr_len;
   logic [16:0]        len_span;
   logic [31:0]        elapsed_next;
   logic [FRAME_W-1:0] seen_next;
   logic               final_frame;
   logic [2:0]         tail_rem;

   assign hdr_id  = {req.byte_2, req.byte_1};
   assign hdr_cmd = {req.byte_4, req.byte_3};
   assign hdr_len = {req.byte_6, req.byte_5};

   always_comb begin
      collecting_in = collecting_ff;
      seen_in       = seen_ff;
      left_in       = left_ff;
      elapsed_in    = elapsed_ff;
      cmd_in        = cmd_ff;
      len_in        = len_ff;
      op_valid      = 1'b0;
      op            = '0;
      op.kind       = spd_pkg::OP_ERROR;
      op.command    = cmd_ff;
      op.length     = len_ff;
      op.bytes      = {req.byte_7, req.byte_6, req.byte_5, req.byte_4,
                       req.byte_3, req.byte_2, req.byte_1, req.byte_0};
      len_span      = {1'b0, hdr_len} + 17'd18;
      elapsed_next  = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + 32'd1;
      seen_next     = seen_ff + 1'b1;
      final_frame   = (seen_next >= left_ff);
      tail_rem      = len_ff[2:0] + 3'd3;

      if (accept) begin
         if (req.operation) begin
            if (collecting_ff) begin
               elapsed_in = elapsed_next;
               if (elapsed_next > read_timeout) begin
                  collecting_in = 1'b0;
                  op_valid      = 1'b1;
                  op.status     = spd_pkg::ST_TIMEOUT;
               end
            end
         end else if (!collecting_ff) begin
            op_valid   = 1'b1;
            op.command = '0;
            op.length  = '0;
            priority if (req.byte_0 != spd_pkg::START_BYTE) begin
               op.status = spd_pkg::ST_BAD_START;
            end else if (hdr_id != sensor_id) begin
               op.status = spd_pkg::ST_WRONG_ID;
            end else if (!spd_pkg::command_known(hdr_cmd)) begin
               op.status  = spd_pkg::ST_BAD_CMD;
               op.command = hdr_cmd;
            end else if (hdr_len > 16'(MAX_PAYLOAD)) begin
               op.status  = spd_pkg::ST_TOO_LONG;
               op.command = hdr_cmd;
               op.length  = hdr_len;
            end else begin
               op.kind       = spd_pkg::OP_START;
               op.command    = hdr_cmd;
               op.length     = hdr_len;
               op.pos        = '0;
               op.count      = 4'd1;
               op.bytes      = {56'd0, req.byte_7};
               collecting_in = 1'b1;
               seen_in       = '0;
               left_in       = FRAME_W'(len_span >> 3) - 1'b1;
               elapsed_in    = '0;
               cmd_in        = hdr_cmd;
               len_in        = hdr_len;
            end
         end else begin
            op_valid       = 1'b1;
            op.kind        = spd_pkg::OP_DATA;
            op.final_frame = final_frame;
            op.pos         = spd_pkg::POS_W'({seen_ff, 3'b001});
            op.count       = 4'd8;
            if (final_frame && tail_rem != 3'd0) begin
               op.count = {1'b0, tail_rem};
            end
            seen_in = seen_next;
            if (final_frame) begin
               collecting_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         collecting_ff <= 1'b0;
         seen_ff       <= '0;
         left_ff       <= '0;
         elapsed_ff    <= '0;
         cmd_ff        <= '0;
         len_ff        <= '0;
      end else begin
         collecting_ff <= collecting_in;
         seen_ff       <= seen_in;
         left_ff       <= left_in;
         elapsed_ff    <= elapsed_in;
         cmd_ff        <= cmd_in;
         len_ff        <= len_in;
      end
   end

endmodule

/* rtl/spd_back.sv */
// Back end: stores packet bytes in eight byte lanes, checks the packet, emits results.
module spd_back #(
   parameter int MAX_PAYLOAD = spd_pkg::MAX_PAYLOAD_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [15:0]      sensor_id,
   input  spd_pkg::op_type  head_op,
   input  logic             q_empty,
   output logic             q_pop,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output spd_pkg::rsp_type rsp_data
);

   localparam int ROWS  = (MAX_PAYLOAD + 3) / 8 + 1;
   localparam int ROW_W = $clog2(ROWS);
   localparam int POS_W = spd_pkg::POS_W;

   typedef enum logic [2:0] {
      B_IDLE  = 3'b001,
      B_CHECK = 3'b010,
      B_EMIT  = 3'b100
   } back_state_type;

   back_state_type   state_ff, state_in;
   logic [15:0]      cmd_ff, cmd_in;
   logic [15:0]      len_ff, len_in;
   logic [15:0]      sum_ff, sum_in;
   logic [7:0]       chk_lo_ff, chk_lo_in;
   logic [7:0]       chk_hi_ff, chk_hi_in;
   logic [7:0]       cr_ff, cr_in;
   logic [7:0]       lf_ff, lf_in;
   logic [2:0]       word_ff, word_in;
   logic             rsp_valid_ff, rsp_valid_in;
   spd_pkg::rsp_type rsp_ff, rsp_in;

   logic             lane_we [8];
   logic [ROW_W-1:0] lane_row [8];
   logic [7:0]       lane_wd [8];
   logic [7:0]       lane_rd [8];

   logic             do_write;
   logic             out_free;
   logic [10:0]      frame_sum;
   logic [15:0]      sum_base;
   logic [2:0]       slot;
   logic [POS_W-1:0] pos;
   logic [15:0]      len_m1;
   logic [2:0]       words_m1;
   logic [63:0]      word_data;
   logic [5:0]       byte_pos;

   assign out_free  = !rsp_valid_ff || rsp_pop;
   assign do_write  = (state_ff == B_IDLE) && !q_empty
                      && (head_op.kind == spd_pkg::OP_START || head_op.kind == spd_pkg::OP_DATA);
   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Lane writes, running checksum and capture of the check and trailer bytes.
   always_comb begin
      frame_sum = '0;
      chk_lo_in = chk_lo_ff;
      chk_hi_in = chk_hi_ff;
      cr_in     = cr_ff;
      lf_in     = lf_ff;
      slot      = '0;
      pos       = '0;
      for (int lane = 0; lane < 8; lane++) begin
         slot           = 3'(lane) - head_op.pos[2:0];
         pos            = head_op.pos + POS_W'(slot);
         lane_we[lane]  = do_write && ({1'b0, slot} < head_op.count);
         lane_row[lane] = ROW_W'(pos >> 3);
         lane_wd[lane]  = head_op.bytes[slot];
         if (lane_we[lane]) begin
            if (16'(pos) < head_op.length) begin
               frame_sum = frame_sum + 11'(head_op.bytes[slot]);
            end
            if (16'(pos) == head_op.length) begin
               chk_lo_in = head_op.bytes[slot];
            end
            if (16'(pos) == head_op.length + 16'd1) begin
               chk_hi_in = head_op.bytes[slot];
            end
            if (16'(pos) == head_op.length + 16'd2) begin
               cr_in = head_op.bytes[slot];
            end
            if (16'(pos) == head_op.length + 16'd3) begin
               lf_in = head_op.bytes[slot];
            end
         end
      end
   end

   always_comb begin
      sum_base = sum_ff;
      if (head_op.kind == spd_pkg::OP_START) begin
         sum_base = sensor_id + head_op.command + head_op.length;
      end
   end

   always_comb begin
      len_m1   = len_ff - 16'd1;
      words_m1 = '0;
      if (len_ff != '0) begin
         words_m1 = (len_m1[15:3] > 13'd7) ? 3'd7 : len_m1[5:3];
      end
      byte_pos  = '0;
      word_data = '0;
      for (int b = 0; b < 8; b++) begin
         byte_pos = {word_ff, 3'(b)};
         if (16'(byte_pos) < len_ff) begin
            word_data[8*b +: 8] = lane_rd[b];
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      len_in       = len_ff;
      sum_in       = sum_ff;
      word_in      = '0;
      q_pop        = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      rsp_in       = rsp_ff;

      unique case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               unique case (head_op.kind)
                  spd_pkg::OP_START: begin
                     q_pop  = 1'b1;
                     cmd_in = head_op.command;
                     len_in = head_op.length;
                     sum_in = sum_base + 16'(frame_sum);
                  end
                  spd_pkg::OP_DATA: begin
                     q_pop  = 1'b1;
                     sum_in = sum_base + 16'(frame_sum);
                     if (head_op.final_frame) begin
                        state_in = B_CHECK;
                     end
                  end
                  spd_pkg::OP_ERROR: begin
                     if (out_free) begin
                        q_pop                 = 1'b1;
                        rsp_valid_in          = 1'b1;
                        rsp_in.status         = head_op.status;
                        rsp_in.command        = head_op.command;
                        rsp_in.payload_length = head_op.length;
                        rsp_in.word_index     = '0;
                        rsp_in.payload_word   = '0;
                        rsp_in.last           = 1'b1;
                     end
                  end
                  default: begin
                     q_pop = 1'b1;
                  end
               endcase
            end
         end
         B_CHECK: begin
            if (cr_ff == spd_pkg::TRAIL_CR && lf_ff == spd_pkg::TRAIL_LF
                && sum_ff == {chk_hi_ff, chk_lo_ff}) begin
               state_in = B_EMIT;
            end else if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_in.status         = spd_pkg::ST_TRAILER;
               if (cr_ff == spd_pkg::TRAIL_CR && lf_ff == spd_pkg::TRAIL_LF) begin
                  rsp_in.status = spd_pkg::ST_CHECKSUM;
               end
               rsp_in.command        = cmd_ff;
               rsp_in.payload_length = len_ff;
               rsp_in.word_index     = '0;
               rsp_in.payload_word   = '0;
               rsp_in.last           = 1'b1;
               state_in              = B_IDLE;
            end
         end
         B_EMIT: begin
            word_in = word_ff;
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_in.status         = spd_pkg::ST_OK;
               rsp_in.command        = cmd_ff;
               rsp_in.payload_length = len_ff;
               rsp_in.word_index     = word_ff;
               rsp_in.payload_word   = word_data;
               rsp_in.last           = (word_ff == words_m1);
               if (word_ff == words_m1) begin
                  state_in = B_IDLE;
               end else begin
                  word_in = word_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   for (genvar lane = 0; lane < 8; lane++) begin : g_lane
      spd_ram #(
         .WIDTH(8),
         .DEPTH(ROWS)
      ) u_lane_ram (
         .clock  (clock),
         .wr_en  (lane_we[lane]),
         .wr_addr(lane_row[lane]),
         .wr_data(lane_wd[lane]),
         .rd_addr(ROW_W'(word_in)),
         .rd_data(lane_rd[lane])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         word_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         word_ff      <= word_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      len_ff    <= len_in;
      sum_ff    <= sum_in;
      chk_lo_ff <= chk_lo_in;
      chk_hi_ff <= chk_hi_in;
      cr_ff     <= cr_in;
      lf_ff     <= lf_in;
      rsp_ff    <= rsp_in;
   end

endmodule

/* rtl/sensor_packet_deframer_core.sv */
// Top level of the sensor packet deframer: registers, front end, queue and back end.
//
// Requests enter on req_data with push/full: a link frame (operation 0) or one
// time tick (operation 1). A header frame is checked for start byte, sensor id,
// command and length; later frames are stored until the last frame of the
// packet, whose check and trailer bytes are then verified.
// Results leave on rsp_data with empty/pop: one result per 8-byte payload word
// (up to eight) or a single error result, the final one marked by last.
// The front end takes one request per cycle while its four-entry queue has
// room. The back end stores frames in state B_IDLE, checks a finished packet
// in B_CHECK and emits its result words in B_EMIT; it takes no new frame until
// the last result of the packet is out. A header error passes through the queue
// and the result register to the result side; the first word of a good packet
// passes through the queue, B_CHECK, B_EMIT and the result register.
// While the result is not popped the back end holds it, the queue fills and
// full rises; nothing is dropped.
// Configuration writes use csr_we, csr_index and csr_wdata and take effect at
// the next edge. Reset sets the sensor id to 1, the timeout to 100000 ticks,
// empties the queue and the result register, and leaves the block idle.
module sensor_packet_deframer_core #(
   parameter int MAX_PAYLOAD = spd_pkg::MAX_PAYLOAD_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  spd_pkg::req_type req_data,
   output logic             empty,
   input  logic             pop,
   output spd_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [31:0]      csr_wdata
);

   logic [15:0]     sensor_id_ff, sensor_id_in;
   logic [31:0]     timeout_ff, timeout_in;
   logic            req_accept;
   logic            op_valid;
   spd_pkg::op_type front_op;
   spd_pkg::op_type head_op;
   logic            q_empty;
   logic            q_pop;

   assign req_accept = push && !full;

   always_comb begin
      sensor_id_in = sensor_id_ff;
      timeout_in   = timeout_ff;
      if (csr_we) begin
         unique case (csr_index)
            spd_pkg::CSR_SENSOR_ID:    sensor_id_in = csr_wdata[15:0];
            spd_pkg::CSR_READ_TIMEOUT: timeout_in   = csr_wdata;
            default:                   sensor_id_in = sensor_id_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sensor_id_ff <= spd_pkg::SENSOR_ID_RESET;
         timeout_ff   <= spd_pkg::TIMEOUT_RESET;
      end else begin
         sensor_id_ff <= sensor_id_in;
         timeout_ff   <= timeout_in;
      end
   end

   spd_front #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .req         (req_data),
      .sensor_id   (sensor_id_ff),
      .read_timeout(timeout_ff),
      .op_valid    (op_valid),
      .op          (front_op)
   );

   spd_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (op_valid),
      .push_op(front_op),
      .full   (full),
      .pop    (q_pop),
      .head_op(head_op),
      .empty  (q_empty)
   );

   spd_back #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .sensor_id(sensor_id_ff),
      .head_op  (head_op),
      .q_empty  (q_empty),
      .q_pop    (q_pop),
      .rsp_empty(empty),
      .rsp_pop  (pop),
      .rsp_data (rsp_data)
   );

endmodule
